// ----- rtl/core/gait_parameter_ramp_top_assert.svh -----
// Assertion helpers for the gait ramp RTL.
`ifndef GAIT_PARAMETER_RAMP_TOP_ASSERT_SVH
`define GAIT_PARAMETER_RAMP_TOP_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define GPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gait ramp assertion failed");

// Next-cycle implication, checked outside of reset.
`define GPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gait ramp assertion failed");

`endif

// ----- rtl/core/gpr_pkg.sv -----
package gpr_pkg;

    // Accumulator and counter sizing.
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int IO_WIDTH    = 16;
    localparam int RAMP_WIDTH  = 16;
    localparam int CHANNELS    = 6;
    localparam int CHAN_W      = $clog2(CHANNELS);
    localparam int CMP_W       = (COUNT_WIDTH > RAMP_WIDTH) ? COUNT_WIDTH : RAMP_WIDTH;

    // Serial divider: one quotient bit per cycle over the difference magnitude.
    localparam int DIV_WIDTH = VALUE_WIDTH + 1;
    localparam int DIV_CNT_W = $clog2(DIV_WIDTH + 1);

    localparam logic [RAMP_WIDTH-1:0] RAMP_RESET = RAMP_WIDTH'(1000);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic signed [IO_WIDTH-1:0]    t_io;

    localparam t_value ONE_FIXED  = t_value'(1) << (VALUE_WIDTH - 4);
    localparam t_value HALF_FIXED = t_value'(1) << (VALUE_WIDTH - 5);

    // Power-up value of each channel: biases 0, 0.5, 0.5, 0, duty 0.5, period 1.0.
    function automatic t_value reset_value(input logic [CHAN_W-1:0] ch);
        t_value v;
        case (ch)
            CHAN_W'(0), CHAN_W'(3): v = '0;
            CHAN_W'(1), CHAN_W'(2), CHAN_W'(4): v = HALF_FIXED;
            default: v = ONE_FIXED;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/gait_parameter_ramp_top.sv -----
// Channel  | Direction | Handshake            | Contents
// input    | in        | i_valid / o_ready    | i_command, i_target_* (six Q4.12 targets)
// output   | out       | o_valid / i_ready    | o_bias_1..4, o_duty, o_period, o_ramping
// config   | in        | i_cfg_we             | i_cfg_data (ramp_steps), taken at once
// A load word takes the six channels in turn through the single serial divider,
// which produces one quotient bit per cycle over a 33-bit magnitude. For a tick
// word one shared adder visits the six channels, then the results are registered.
// Reset is synchronous and active low and restores the power-up channel values.
// A stalled output holds the finished tick in the last sequencer step; the block
// is not ready while a word is in progress.
module gait_parameter_ramp_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_command,
    input  logic signed [gpr_pkg::IO_WIDTH-1:0]   i_target_bias_1,
    input  logic signed [gpr_pkg::IO_WIDTH-1:0]   i_target_bias_2,
    input  logic signed [gpr_pkg::IO_WIDTH-1:0]   i_target_bias_3,
    input  logic signed [gpr_pkg::IO_WIDTH-1:0]   i_target_bias_4,
    input  logic signed [gpr_pkg::IO_WIDTH-1:0]   i_target_duty,
    input  logic signed [gpr_pkg::IO_WIDTH-1:0]   i_target_period,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [gpr_pkg::IO_WIDTH-1:0]   o_bias_1,
    output logic signed [gpr_pkg::IO_WIDTH-1:0]   o_bias_2,
    output logic signed [gpr_pkg::IO_WIDTH-1:0]   o_bias_3,
    output logic signed [gpr_pkg::IO_WIDTH-1:0]   o_bias_4,
    output logic signed [gpr_pkg::IO_WIDTH-1:0]   o_duty,
    output logic signed [gpr_pkg::IO_WIDTH-1:0]   o_period,
    output logic                                  o_ramping,
    input  logic                                  i_cfg_we,
    input  logic [gpr_pkg::RAMP_WIDTH-1:0]        i_cfg_data
);

    `include "gait_parameter_ramp_top_assert.svh"

    localparam int VW  = gpr_pkg::VALUE_WIDTH;
    localparam int IOW = gpr_pkg::IO_WIDTH;
    localparam int CH  = gpr_pkg::CHANNELS;
    localparam int CW  = gpr_pkg::CHAN_W;
    localparam int DW  = gpr_pkg::DIV_WIDTH;
    localparam int RW  = gpr_pkg::RAMP_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_DIFF,
        S_LD_ABS,
        S_LD_DIV,
        S_LD_STORE,
        S_TK_ADD,
        S_TK_DONE
    } t_state;

    t_state                            r_state;
    gpr_pkg::t_value                   r_cur  [CH];
    gpr_pkg::t_value                   r_step [CH];
    gpr_pkg::t_io                      r_tgt  [CH];
    gpr_pkg::t_io                      r_out  [CH];
    logic [RW-1:0]                     r_ramp;
    logic [gpr_pkg::COUNT_WIDTH-1:0]   r_cnt;
    logic [CW-1:0]                     r_chan;
    logic signed [VW:0]                r_diff;
    logic                              r_neg;
    logic [RW:0]                       r_rem;
    logic [DW-1:0]                     r_quo;
    logic [gpr_pkg::DIV_CNT_W-1:0]     r_iter;
    logic                              r_run;
    logic                              r_o_valid;
    logic                              r_ramping;

    gpr_pkg::t_value                   cur_sel;
    gpr_pkg::t_value                   step_sel;
    gpr_pkg::t_value                   tgt_val;
    logic signed [VW:0]                diff_full;
    logic [DW-1:0]                     diff_mag;
    logic [RW:0]                       rem_shift;
    logic                              div_ge;
    logic [RW:0]                       n_rem;
    logic [DW-1:0]                     n_quo;
    logic [DW-1:0]                     quo_signed;
    gpr_pkg::t_value                   n_step;
    gpr_pkg::t_value                   n_sum;
    logic                              still_ramping;
    logic                              last_chan;

    // Channel operands selected by the sequencer's channel index.
    assign cur_sel  = r_cur[r_chan];
    assign step_sel = r_step[r_chan];
    assign tgt_val  = {r_tgt[r_chan], {(VW - IOW){1'b0}}};

    // Target minus current, one bit wider so it cannot overflow.
    assign diff_full = {tgt_val[VW-1], tgt_val} - {cur_sel[VW-1], cur_sel};
    assign diff_mag  = r_diff[VW] ? DW'(-r_diff) : DW'(r_diff);

    // One restoring division step per cycle.
    assign rem_shift = {r_rem[RW-1:0], r_quo[DW-1]};
    assign div_ge    = rem_shift >= {1'b0, r_ramp};
    assign n_rem     = div_ge ? (rem_shift - {1'b0, r_ramp}) : rem_shift;
    assign n_quo     = {r_quo[DW-2:0], div_ge};

    // Quotient truncated toward zero, then wrapped to the accumulator width.
    assign quo_signed = r_neg ? (~r_quo + DW'(1)) : r_quo;
    assign n_step     = (r_ramp == '0) ? '0 : quo_signed[VW-1:0];

    // Shared accumulate adder for ticks.
    assign n_sum = cur_sel + step_sel;

    // Counter below the ramp length and below its own ceiling.
    assign still_ramping = (gpr_pkg::CMP_W'(r_cnt) < gpr_pkg::CMP_W'(r_ramp))
                           && (r_cnt != '1);
    assign last_chan = (r_chan == CW'(CH - 1));

    // Sequencer, channel state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ramp    <= gpr_pkg::RAMP_RESET;
            r_cnt     <= '0;
            r_chan    <= '0;
            r_iter    <= '0;
            r_run     <= 1'b0;
            r_o_valid <= 1'b0;
            r_ramping <= 1'b0;
            for (int c = 0; c < CH; c++) begin
                r_cur[c]  <= gpr_pkg::reset_value(CW'(c));
                r_step[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_ramp <= i_cfg_data;
            end
            // A taken result word clears valid unless the last step refills it.
            if (r_o_valid && i_ready && (r_state != S_TK_DONE)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tgt[0] <= i_target_bias_1;
                        r_tgt[1] <= i_target_bias_2;
                        r_tgt[2] <= i_target_bias_3;
                        r_tgt[3] <= i_target_bias_4;
                        r_tgt[4] <= i_target_duty;
                        r_tgt[5] <= i_target_period;
                        r_chan   <= '0;
                        r_run    <= still_ramping;
                        r_state  <= i_command ? S_TK_ADD : S_LD_DIFF;
                    end
                end
                S_LD_DIFF: begin
                    r_diff  <= diff_full;
                    r_state <= S_LD_ABS;
                end
                S_LD_ABS: begin
                    r_neg   <= r_diff[VW];
                    r_quo   <= diff_mag;
                    r_rem   <= '0;
                    r_iter  <= '0;
                    r_state <= S_LD_DIV;
                end
                S_LD_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= n_quo;
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == gpr_pkg::DIV_CNT_W'(DW - 1)) begin
                        r_state <= S_LD_STORE;
                    end
                end
                S_LD_STORE: begin
                    r_step[r_chan] <= n_step;
                    if (last_chan) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_chan  <= r_chan + 1'b1;
                        r_state <= S_LD_DIFF;
                    end
                end
                S_TK_ADD: begin
                    if (r_run) begin
                        r_cur[r_chan] <= n_sum;
                    end
                    if (last_chan) begin
                        if (r_run) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= S_TK_DONE;
                    end else begin
                        r_chan <= r_chan + 1'b1;
                    end
                end
                S_TK_DONE: begin
                    // Wait here while the previous result word is still pending.
                    if (!r_o_valid || i_ready) begin
                        for (int c = 0; c < CH; c++) begin
                            r_out[c] <= r_cur[c][VW-1 -: IOW];
                        end
                        r_ramping <= still_ramping;
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_o_valid;
    assign o_bias_1  = r_out[0];
    assign o_bias_2  = r_out[1];
    assign o_bias_3  = r_out[2];
    assign o_bias_4  = r_out[3];
    assign o_duty    = r_out[4];
    assign o_period  = r_out[5];
    assign o_ramping = r_ramping;

    // The block goes busy as soon as it takes a word.
    `GPR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // A load word never produces a result word.
    `GPR_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, i_valid && o_ready && !i_command && !o_valid, !o_valid)
    // The step counter only clears or advances by one.
    `GPR_ASSERT_IMPL(a_count_step, i_clk, i_rst_n, !$stable(r_cnt), (r_cnt == $past(r_cnt) + 1'b1) || (r_cnt == '0))
    // The divider never runs past its quotient width.
    `GPR_ASSERT_IMPL(a_iter_range, i_clk, i_rst_n, r_state == S_LD_DIV, r_iter < gpr_pkg::DIV_CNT_W'(DW))

endmodule

// ----- sim/gpr_tb_pkg.sv -----
package gpr_tb_pkg;

    // Command carried by each input word.
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } ramp_cmd_e;

endpackage

// ----- sim/gait_parameter_ramp_checker.sv -----
module gait_parameter_ramp_checker
    import gpr_pkg::*;
    import gpr_tb_pkg::*;
(
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic                               i_command,
    input  logic [CHANNELS-1:0][IO_WIDTH-1:0]  i_targets,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [CHANNELS-1:0][IO_WIDTH-1:0]  i_values,
    input  logic                               i_ramping,
    input  logic                               i_cfg_we,
    input  logic [RAMP_WIDTH-1:0]              i_cfg_data,
    output int                                 o_failures,
    output int                                 o_pending
);

    // One tick result: channel 0 is leg 1 bias, channel 5 is the period.
    typedef struct packed {
        logic [CHANNELS-1:0][IO_WIDTH-1:0] value;
        logic                              ramping;
    } tick_result_t;

    // Shadow copy of the channel accumulators, steps, counter and register.
    t_value                 chan_acc  [CHANNELS];
    t_value                 chan_step [CHANNELS];
    logic [COUNT_WIDTH-1:0] tick_count;
    logic [RAMP_WIDTH-1:0]  ramp_len;
    tick_result_t           expected_ticks [$];

    // The ramp runs while the counter is below the register and not saturated.
    function automatic logic ramp_active();
        return (CMP_W'(tick_count) < CMP_W'(ramp_len)) && (tick_count != '1);
    endfunction

    // Predict on every accepted input word, compare every accepted result word.
    always @(posedge i_clk) begin : predict_and_compare
        tick_result_t want;
        tick_result_t got;
        t_value       tgt;
        longint       diff;
        if (!i_rst_n) begin
            chan_acc[0] = '0;
            chan_acc[1] = HALF_FIXED;
            chan_acc[2] = HALF_FIXED;
            chan_acc[3] = '0;
            chan_acc[4] = HALF_FIXED;
            chan_acc[5] = ONE_FIXED;
            for (int c = 0; c < CHANNELS; c++) begin
                chan_step[c] = '0;
            end
            tick_count = '0;
            ramp_len = RAMP_RESET;
            expected_ticks.delete();
            o_failures = 0;
        end else begin
            if (i_cfg_we) begin
                ramp_len = i_cfg_data;
            end

            if (i_in_valid && i_in_ready) begin
                if (i_command == CMD_LOAD) begin
                    // Step is the signed difference divided toward zero, kept wrapped.
                    for (int c = 0; c < CHANNELS; c++) begin
                        tgt = {i_targets[c], {(VALUE_WIDTH - IO_WIDTH){1'b0}}};
                        if (ramp_len == '0) begin
                            chan_step[c] = '0;
                        end else begin
                            diff = longint'(tgt) - longint'(chan_acc[c]);
                            chan_step[c] = t_value'(diff / longint'(ramp_len));
                        end
                    end
                    tick_count = '0;
                end else begin
                    if (ramp_active()) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            chan_acc[c] = chan_acc[c] + chan_step[c];
                        end
                        tick_count = tick_count + 1'b1;
                    end
                    for (int c = 0; c < CHANNELS; c++) begin
                        want.value[c] = chan_acc[c][VALUE_WIDTH-1 -: IO_WIDTH];
                    end
                    want.ramping = ramp_active();
                    expected_ticks.push_back(want);
                end
            end

            if (i_out_valid && i_out_ready) begin
                got.value = i_values;
                got.ramping = i_ramping;
                if (expected_ticks.size() == 0) begin
                    if (o_failures < 10) begin
                        $display("unexpected result word: values %h ramping %0d",
                                 got.value, got.ramping);
                    end
                    o_failures++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (got != want) begin
                        if (o_failures < 10) begin
                            $display("result mismatch: expected values %h ramping %0d",
                                     want.value, want.ramping);
                            $display("                 actual   values %h ramping %0d",
                                     got.value, got.ramping);
                        end
                        o_failures++;
                    end
                end
            end
        end
        o_pending = expected_ticks.size();
    end

endmodule

// ----- sim/tb_gait_parameter_ramp_top.sv -----
module tb_gait_parameter_ramp_top;

    import gpr_pkg::*;
    import gpr_tb_pkg::*;

    localparam int ITEM_GOAL    = 1200;
    localparam int CALM_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 240;
    localparam int LONG_HOLD    = 400;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_ready;
    logic                              i_command;
    logic [CHANNELS-1:0][IO_WIDTH-1:0] target_word;
    logic                              o_valid;
    logic                              i_ready;
    wire  [CHANNELS-1:0][IO_WIDTH-1:0] value_word;
    logic                              o_ramping;
    logic                              i_cfg_we;
    logic [RAMP_WIDTH-1:0]             i_cfg_data;

    int failures;
    int pending;
    int item_count;
    int cycle_count;
    bit calm;
    bit rx_hold_req;

    gait_parameter_ramp_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_target_bias_1 (target_word[0]),
        .i_target_bias_2 (target_word[1]),
        .i_target_bias_3 (target_word[2]),
        .i_target_bias_4 (target_word[3]),
        .i_target_duty   (target_word[4]),
        .i_target_period (target_word[5]),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_bias_1        (value_word[0]),
        .o_bias_2        (value_word[1]),
        .o_bias_3        (value_word[2]),
        .o_bias_4        (value_word[3]),
        .o_duty          (value_word[4]),
        .o_period        (value_word[5]),
        .o_ramping       (o_ramping),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    gait_parameter_ramp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_command   (i_command),
        .i_targets   (target_word),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_values    (value_word),
        .i_ramping   (o_ramping),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        i_ready = 1'b0;
        forever begin
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Random targets, leaning on the extremes now and then.
    function automatic logic [CHANNELS-1:0][IO_WIDTH-1:0] rand_targets();
        logic [CHANNELS-1:0][IO_WIDTH-1:0] tg;
        for (int c = 0; c < CHANNELS; c++) begin
            case ($urandom_range(0, 9))
                0: tg[c] = 16'h7FFF;
                1: tg[c] = 16'h8000;
                2: tg[c] = 16'hFFFF;
                default: tg[c] = IO_WIDTH'($urandom);
            endcase
        end
        return tg;
    endfunction

    // Offer one word, optionally after an idle burst, and wait until it is taken.
    task automatic send_word(input ramp_cmd_e cmd,
                             input logic [CHANNELS-1:0][IO_WIDTH-1:0] tg);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        target_word <= tg;
        do @(posedge i_clk); while (!o_ready);
        item_count++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_word(CMD_TICK, rand_targets());
    endtask

    // Change the ramp length only once the block has gone quiet.
    task automatic write_ramp(input logic [RAMP_WIDTH-1:0] steps);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= steps;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Stimulus and verdict.
    initial begin
        int                    phase_no;
        int                    tick_len;
        logic [RAMP_WIDTH-1:0] ramp;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_command   = CMD_LOAD;
        target_word = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        calm        = 1'b0;
        rx_hold_req = 1'b0;
        item_count  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Power-up values under the reset ramp length, then a slow ramp upward.
        send_ticks(1);
        send_word(CMD_LOAD, {CHANNELS{16'h7FFF}});
        send_ticks(2);

        // One-tick ramps land on the target even when the step wraps.
        write_ramp(16'd1);
        send_word(CMD_LOAD, {CHANNELS{16'h8000}});
        send_ticks(2);
        send_word(CMD_LOAD, {CHANNELS{16'h7FFF}});
        send_ticks(1);
        send_word(CMD_LOAD, {16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE, 16'h7FFF, 16'h8000});
        send_ticks(1);

        // A zero ramp length freezes the channels.
        write_ramp(16'd0);
        send_word(CMD_LOAD, rand_targets());
        send_ticks(2);

        // Longest ramp length.
        write_ramp(16'hFFFF);
        send_word(CMD_LOAD, rand_targets());
        send_ticks(2);

        // Short ramp that runs out, so the ramping flag drops.
        write_ramp(16'd3);
        send_word(CMD_LOAD, rand_targets());
        send_ticks(4);

        // Random phases: a new ramp length each, then ramps and noise.
        phase_no = 0;
        while (item_count < ITEM_GOAL) begin
            phase_no++;
            calm = (item_count > ITEM_GOAL - CALM_ITEMS) || ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: ramp = '0;
                1: ramp = 16'd1;
                2: ramp = 16'hFFFF;
                3: ramp = RAMP_WIDTH'($urandom);
                default: ramp = RAMP_WIDTH'($urandom_range(2, 12));
            endcase
            write_ramp(ramp);

            // Hold the result side off so the block backs up into its input.
            if (phase_no == 1) begin
                rx_hold_req = 1'b1;
                send_word(CMD_LOAD, rand_targets());
                send_ticks(25);
            end

            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 9) < 7) begin
                    // Full ramp; sometimes without a load, so an older ramp resumes.
                    if ($urandom_range(0, 4) != 0) begin
                        send_word(CMD_LOAD, rand_targets());
                    end
                    if (ramp == '0) begin
                        tick_len = $urandom_range(1, 4);
                    end else if (ramp <= 20) begin
                        tick_len = int'(ramp) + $urandom_range(0, 3);
                    end else begin
                        tick_len = $urandom_range(1, 20);
                    end
                    send_ticks(tick_len);
                end else begin
                    repeat ($urandom_range(3, 10)) begin
                        send_word(ramp_cmd_e'($urandom_range(0, 1)), rand_targets());
                    end
                end
            end
        end

        // Drain and decide.
        calm = 1'b1;
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- gait_parameter_ramp_top.f -----
+incdir+rtl/core
rtl/core/gpr_pkg.sv
rtl/core/gait_parameter_ramp_top.sv
sim/gpr_tb_pkg.sv
sim/gait_parameter_ramp_checker.sv
sim/tb_gait_parameter_ramp_top.sv
